// ===== sv/cartridge_bank_controller_core_macros.svh =====
// Assertion macros shared by the controller RTL.
`ifndef CARTRIDGE_BANK_CONTROLLER_CORE_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cbc_pkg.sv =====
`timescale 1ns / 1ps

package cbc_pkg;

	localparam int MAX_ROM_BANKS = 128;
	localparam int MAX_RAM_BANKS = 4;

	// Mapper kinds; the unused code behaves as no mapper
	typedef enum logic [1:0] {
		MAPPER_NONE = 2'd0,
		MAPPER_MBC1 = 2'd1,
		MAPPER_MBC2 = 2'd2,
		MAPPER_RSVD = 2'd3
	} mapper_kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAPPER_KIND    = 2'd0,
		CFG_ROM_BANK_COUNT = 2'd1,
		CFG_RAM_BANK_COUNT = 2'd2,
		CFG_RAM_BANKING    = 2'd3
	} cfg_index_t;

	typedef enum logic {
		ACC_READ  = 1'b0,
		ACC_WRITE = 1'b1
	} access_kind_t;

	typedef enum logic [1:0] {
		REGION_ROM  = 2'd0,
		REGION_RAM  = 2'd1,
		REGION_NONE = 2'd2,
		REGION_RSVD = 2'd3
	} region_t;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  value;
	} req_t;

	typedef struct packed {
		logic [1:0]  region;
		logic [21:0] phys_offset;
		logic        data_enabled;
		logic        control_write;
	} rsp_t;

	// ROM bank mask from the configured bank count
	function automatic logic [6:0] rom_mask(input logic [7:0] cnt);
		logic [7:0] d;
		d = cnt - 8'd1;
		return d[6:0] & 7'(MAX_ROM_BANKS - 1);
	endfunction

	// Bytes of ROM ahead of the RAM area in the store
	function automatic logic [21:0] rom_bytes(input logic [7:0] cnt);
		logic [7:0] n;
		n = (cnt > 8'(MAX_ROM_BANKS)) ? 8'(MAX_ROM_BANKS) : cnt;
		return {n, 14'd0};
	endfunction

	function automatic logic [2:0] ram_count(input logic [2:0] cnt);
		return (cnt > 3'(MAX_RAM_BANKS)) ? 3'(MAX_RAM_BANKS) : cnt;
	endfunction

	// MBC1 upper ROM window: bank 0 maps to 1, 0x20/0x40/0x60 skip up in ROM mode
	function automatic logic [6:0] mbc1_rom_win(input logic mode, input logic [1:0] high,
			input logic [4:0] low, input logic [6:0] mask);
		logic [6:0] n;
		n = (mode ? {2'b00, low} : {high, low}) & mask;
		if (n < 7'd2)
			return 7'd1;
		else if (mode || (n != 7'h20 && n != 7'h40 && n != 7'h60))
			return n;
		else
			return n + 7'd1;
	endfunction

	// MBC1 RAM window; keeps the old bank unless banking applies
	function automatic logic [1:0] mbc1_ram_win(input logic allowed, input logic [2:0] cnt,
			input logic en, input logic mode, input logic [1:0] high, input logic [1:0] old);
		logic [2:0] c;
		logic [2:0] cm1;
		c = ram_count(cnt);
		cm1 = c - 3'd1;
		if (!allowed || c < 3'd2 || !en)
			return old;
		else if (mode)
			return high & cm1[1:0] & 2'(MAX_RAM_BANKS - 1);
		else
			return 2'd0;
	endfunction

endpackage

// ===== sv/cartridge_bank_controller_core.sv =====
`timescale 1ns / 1ps
// The req beat enters the input register, then its result enters the result register for the rsp beat.
// Throughput: one access per cycle without rsp stalls; mapper state updates in the same pass that forms the result.
// Back-pressure on rsp holds the input register and drops req_ready.
// Reset (arst_n low, async): no mapper, 2 ROM banks, no RAM, RAM disabled, ROM window bank 1.
`include "cartridge_bank_controller_core_macros.svh"

module cartridge_bank_controller_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  cbc_pkg::req_t    req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output cbc_pkg::rsp_t    rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	// configuration
	logic [1:0] mapper_kind_q;
	logic [7:0] rom_bank_count_q;
	logic [2:0] ram_bank_count_q;
	logic       ram_banking_q;

	// mapper state
	logic       ram_enable_q;
	logic       banking_mode_q;
	logic [4:0] bank_low_q;
	logic [1:0] bank_high_q;
	logic [3:0] mbc2_bank_q;
	logic [6:0] rom_window_q;
	logic [1:0] ram_window_q;

	logic          valid_s1;
	cbc_pkg::req_t req_s1;
	logic          rsp_valid_q;
	cbc_pkg::rsp_t rsp_q;
	logic          advance;

	logic       ram_enable_d;
	logic       banking_mode_d;
	logic [4:0] bank_low_d;
	logic [1:0] bank_high_d;
	logic [3:0] mbc2_bank_d;
	logic [6:0] rom_window_d;
	logic [1:0] ram_window_d;
	cbc_pkg::rsp_t rsp_d;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q    <= cbc_pkg::MAPPER_NONE;
			rom_bank_count_q <= 8'd2;
			ram_bank_count_q <= 3'd0;
			ram_banking_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cbc_pkg::cfg_index_t'(cfg_index))
				cbc_pkg::CFG_MAPPER_KIND:    mapper_kind_q    <= cfg_data[1:0];
				cbc_pkg::CFG_ROM_BANK_COUNT: rom_bank_count_q <= cfg_data;
				cbc_pkg::CFG_RAM_BANK_COUNT: ram_bank_count_q <= cfg_data[2:0];
				cbc_pkg::CFG_RAM_BANKING:    ram_banking_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// decode, translate and mapper register update
	always_comb begin
		logic [15:0] a;
		logic [7:0]  v;
		logic [6:0]  mask;
		logic        wr;
		logic        m;
		logic [3:0]  e;
		logic [3:0]  b;
		logic [6:0]  n2;
		a    = req_s1.address;
		v    = req_s1.value;
		wr   = (req_s1.kind == cbc_pkg::ACC_WRITE);
		mask = cbc_pkg::rom_mask(rom_bank_count_q);
		m    = (v != 8'd0);
		e    = v[3:0];
		b    = v[3:0];
		n2   = {3'd0, b} & mask;

		ram_enable_d   = ram_enable_q;
		banking_mode_d = banking_mode_q;
		bank_low_d     = bank_low_q;
		bank_high_d    = bank_high_q;
		mbc2_bank_d    = mbc2_bank_q;
		rom_window_d   = rom_window_q;
		ram_window_d   = ram_window_q;

		rsp_d.region        = cbc_pkg::REGION_NONE;
		rsp_d.phys_offset   = 22'd0;
		rsp_d.data_enabled  = 1'b0;
		rsp_d.control_write = 1'b0;

		if (!a[15]) begin
			rsp_d.region = cbc_pkg::REGION_ROM;
			if (wr) begin
				if (mapper_kind_q == cbc_pkg::MAPPER_MBC1) begin
					rsp_d.control_write = 1'b1;
					priority if (a[14:13] == 2'b11) begin
						if (m != banking_mode_q) begin
							banking_mode_d = m;
							rom_window_d = cbc_pkg::mbc1_rom_win(m, bank_high_q, bank_low_q, mask);
							ram_window_d = cbc_pkg::mbc1_ram_win(ram_banking_q, ram_bank_count_q,
								ram_enable_q, m, bank_high_q, ram_window_q);
						end
					end else if (a[14:13] == 2'b10) begin
						if (v[1:0] != bank_high_q) begin
							bank_high_d = v[1:0];
							if (!banking_mode_q)
								rom_window_d = cbc_pkg::mbc1_rom_win(banking_mode_q, v[1:0],
									bank_low_q, mask);
							else
								ram_window_d = cbc_pkg::mbc1_ram_win(ram_banking_q,
									ram_bank_count_q, ram_enable_q, banking_mode_q, v[1:0],
									ram_window_q);
						end
					end else if (a[14:13] == 2'b01) begin
						if (v[4:0] != bank_low_q) begin
							bank_low_d = v[4:0];
							rom_window_d = cbc_pkg::mbc1_rom_win(banking_mode_q, bank_high_q,
								v[4:0], mask);
						end
					end else begin
						if (e == cbc_pkg::RAM_ENABLE_KEY && ram_bank_count_q != 3'd0
								&& !ram_enable_q) begin
							ram_enable_d = 1'b1;
							ram_window_d = cbc_pkg::mbc1_ram_win(ram_banking_q, ram_bank_count_q,
								1'b1, banking_mode_q, bank_high_q, ram_window_q);
						end else if (e != cbc_pkg::RAM_ENABLE_KEY && ram_enable_q) begin
							ram_enable_d = 1'b0;
						end
					end
				end else if (mapper_kind_q == cbc_pkg::MAPPER_MBC2) begin
					rsp_d.control_write = 1'b1;
					if (!a[14]) begin
						if (a[13] && a[8]) begin
							if (b != mbc2_bank_q) begin
								mbc2_bank_d  = b;
								rom_window_d = (n2 < 7'd2) ? 7'd1 : n2;
							end
						end else if (!a[13] && !a[8]) begin
							if (e == cbc_pkg::RAM_ENABLE_KEY)
								ram_enable_d = 1'b1;
							else
								ram_enable_d = 1'b0;
						end
					end
				end
			end else begin
				rsp_d.data_enabled = 1'b1;
				rsp_d.phys_offset = a[14] ? {1'b0, rom_window_q, a[13:0]} : {6'd0, a};
			end
		end else if (a[15:13] == 3'b101) begin
			// cartridge RAM window
			rsp_d.region = cbc_pkg::REGION_RAM;
			if (ram_enable_q) begin
				rsp_d.data_enabled = 1'b1;
				rsp_d.phys_offset  = cbc_pkg::rom_bytes(rom_bank_count_q)
					+ {7'd0, ram_window_q, a[12:0]};
			end
		end
	end

	// input stage, mapper state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			rsp_valid_q    <= 1'b0;
			ram_enable_q   <= 1'b0;
			banking_mode_q <= 1'b0;
			bank_low_q     <= 5'd0;
			bank_high_q    <= 2'd0;
			mbc2_bank_q    <= 4'd0;
			rom_window_q   <= 7'd1;
			ram_window_q   <= 2'd0;
		end else begin
			if (req_valid && req_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				rsp_valid_q    <= 1'b1;
				ram_enable_q   <= ram_enable_d;
				banking_mode_q <= banking_mode_d;
				bank_low_q     <= bank_low_d;
				bank_high_q    <= bank_high_d;
				mbc2_bank_q    <= mbc2_bank_d;
				rom_window_q   <= rom_window_d;
				ram_window_q   <= ram_window_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
		if (advance)
			rsp_q <= rsp_d;
	end

	`CBC_ASSERT_NOW(a_rom_window_nonzero, 1'b1, rom_window_q != 7'd0, "ROM window bank is zero")
	`CBC_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(req_s1), "input stage lost its access")
	`CBC_ASSERT_NEXT(a_state_only_on_advance, !advance, $stable(ram_enable_q) && $stable(rom_window_q) && $stable(ram_window_q) && $stable(banking_mode_q), "mapper state moved without an access")
	`CBC_ASSERT_NOW(a_outside_quiet, rsp_valid_q && rsp_q.region == cbc_pkg::REGION_NONE, !rsp_q.data_enabled && !rsp_q.control_write && rsp_q.phys_offset == 22'd0, "outside access not quiet")
	`CBC_ASSERT_NOW(a_ctl_is_rom, rsp_valid_q && rsp_q.control_write, rsp_q.region == cbc_pkg::REGION_ROM && !rsp_q.data_enabled, "control write outside ROM area")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cbc_pkg::*;

	// Tracks mapper state and holds the translations still owed by the block
	class translation_board;
		logic [1:0] mapper;
		logic [7:0] rom_bank_total;
		logic [2:0] ram_bank_total;
		logic       ram_bankable;
		logic       ram_on;
		logic       ram_mode;
		logic [4:0] low_bits;
		logic [1:0] high_bits;
		logic [3:0] mbc2_bank;
		logic [6:0] rom_win;
		logic [1:0] ram_win;
		rsp_t       expected_q[$];
		int         errors;

		function new();
			mapper = MAPPER_NONE;
			rom_bank_total = 8'd2;
			ram_bank_total = 3'd0;
			ram_bankable = 1'b0;
			ram_on = 1'b0;
			ram_mode = 1'b0;
			low_bits = 5'd0;
			high_bits = 2'd0;
			mbc2_bank = 4'd0;
			rom_win = 7'd1;
			ram_win = 2'd0;
			errors = 0;
		endfunction

		function void configure(logic [1:0] idx, logic [7:0] d);
			case (idx)
			CFG_MAPPER_KIND: mapper = d[1:0];
			CFG_ROM_BANK_COUNT: rom_bank_total = d;
			CFG_RAM_BANK_COUNT: ram_bank_total = d[2:0];
			default: ram_bankable = d[0];
			endcase
		endfunction

		// count 0 wraps to the full seven-bit mask
		function logic [6:0] bank_mask();
			logic [7:0] d;
			d = rom_bank_total - 8'd1;
			return d[6:0];
		endfunction

		function void refresh_rom_win();
			logic [6:0] n;
			n = (ram_mode ? {2'b00, low_bits} : {high_bits, low_bits}) & bank_mask();
			if (n < 7'd2)
				rom_win = 7'd1;
			else if (!ram_mode && (n == 7'h20 || n == 7'h40 || n == 7'h60))
				rom_win = n + 7'd1;
			else
				rom_win = n;
		endfunction

		// RAM window only moves with banking allowed, two or more banks and RAM on
		function void refresh_ram_win();
			int c;
			c = (ram_bank_total > 3'd4) ? 4 : int'(ram_bank_total);
			if (!ram_bankable || c < 2 || !ram_on)
				return;
			ram_win = ram_mode ? (high_bits & 2'(c - 1)) : 2'd0;
		endfunction

		function void mbc1_write(logic [15:0] addr, logic [7:0] v);
			logic m;
			m = (v != 8'd0);
			if (addr >= 16'h6000) begin
				if (m != ram_mode) begin
					ram_mode = m;
					refresh_rom_win();
					refresh_ram_win();
				end
			end else if (addr >= 16'h4000) begin
				if (v[1:0] != high_bits) begin
					high_bits = v[1:0];
					if (!ram_mode)
						refresh_rom_win();
					else
						refresh_ram_win();
				end
			end else if (addr >= 16'h2000) begin
				if (v[4:0] != low_bits) begin
					low_bits = v[4:0];
					refresh_rom_win();
				end
			end else if (v[3:0] == RAM_ENABLE_KEY) begin
				if (ram_bank_total != 3'd0 && !ram_on) begin
					ram_on = 1'b1;
					refresh_ram_win();
				end
			end else begin
				ram_on = 1'b0;
			end
		endfunction

		// address bit 13 picks the register and bit 8 must match it; everything else is ignored
		function void mbc2_write(logic [15:0] addr, logic [7:0] v);
			logic [6:0] n;
			if (addr > 16'h3FFF)
				return;
			if (addr >= 16'h2000 && addr[8]) begin
				if (v[3:0] != mbc2_bank) begin
					mbc2_bank = v[3:0];
					n = {3'b000, mbc2_bank} & bank_mask();
					rom_win = (n < 7'd2) ? 7'd1 : n;
				end
			end else if (addr < 16'h2000 && !addr[8]) begin
				ram_on = (v[3:0] == RAM_ENABLE_KEY);
			end
		endfunction

		function void note_access(req_t r);
			rsp_t e;
			int rom_n;
			e = '0;
			e.region = REGION_NONE;
			if (r.address < 16'h8000) begin
				e.region = REGION_ROM;
				if (r.kind == ACC_WRITE) begin
					if (mapper == MAPPER_MBC1) begin
						mbc1_write(r.address, r.value);
						e.control_write = 1'b1;
					end else if (mapper == MAPPER_MBC2) begin
						mbc2_write(r.address, r.value);
						e.control_write = 1'b1;
					end
				end else begin
					e.data_enabled = 1'b1;
					if (r.address < 16'h4000)
						e.phys_offset = 22'(r.address);
					else
						e.phys_offset = 22'(int'(rom_win) * 'h4000 + int'(r.address) - 'h4000);
				end
			end else if (r.address >= 16'hA000 && r.address < 16'hC000) begin
				e.region = REGION_RAM;
				if (ram_on) begin
					rom_n = (rom_bank_total > 8'd128) ? 128 : int'(rom_bank_total);
					e.data_enabled = 1'b1;
					e.phys_offset = 22'(rom_n * 'h4000 + int'(ram_win) * 'h2000
						+ int'(r.address) - 'hA000);
				end
			end
			expected_q.push_back(e);
		endfunction

		function void report(string field, logic [21:0] exp_v, logic [21:0] act_v);
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
			errors++;
		endfunction

		function void check_translation(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.region !== e.region)
				report("region", 22'(e.region), 22'(got.region));
			if (got.phys_offset !== e.phys_offset)
				report("phys_offset", e.phys_offset, got.phys_offset);
			if (got.data_enabled !== e.data_enabled)
				report("data_enabled", 22'(e.data_enabled), 22'(got.data_enabled));
			if (got.control_write !== e.control_write)
				report("control_write", 22'(e.control_write), 22'(got.control_write));
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	translation_board board = new();
	int idle_odds;
	int stall_odds;
	bit hold_pending;
	bit offering;
	int quiet_cycles = 0;

	cartridge_bank_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Beat monitor: predict on accepted requests, compare on accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				board.note_access(req);
			if (rsp_valid && rsp_ready)
				board.check_translation(rsp);
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 1000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		rsp_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ready <= 1'b0;
				repeat (80) @(posedge clk);
				rsp_ready <= 1'b1;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic req_t access(logic kind, logic [15:0] addr, logic [7:0] val);
		req_t r;
		r.kind = kind;
		r.address = addr;
		r.value = val;
		return r;
	endfunction

	// Mostly mapper writes and windowed reads, with outside and raw noise mixed in
	function automatic req_t random_access();
		req_t r;
		int pick;
		r.kind = 1'($urandom_range(0, 1));
		r.address = 16'($urandom);
		r.value = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			r.kind = ACC_READ;
			r.address[15] = 1'b0;
		end else if (pick < 40) begin
			r.address = 16'hA000 + 16'($urandom_range(0, 'h1FFF));
		end else if (pick < 75) begin
			r.kind = ACC_WRITE;
			r.address[15] = 1'b0;
			case ($urandom_range(0, 4))
			0: r.value[3:0] = RAM_ENABLE_KEY;
			1: r.value = 8'($urandom_range(0, 3));
			2: r.value[4:0] = 5'd0;
			3: r.value = 8'd1;
			default: ;
			endcase
		end else if (pick < 88) begin
			if ($urandom_range(0, 1) == 0)
				r.address = 16'h8000 + 16'($urandom_range(0, 'h1FFF));
			else
				r.address = 16'hC000 + 16'($urandom_range(0, 'h3FFF));
		end
		return r;
	endfunction

	// Offer one request beat; may leave a gap behind it
	task automatic send_access(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		offering = 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			req_valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every owed result to come back
	task automatic settle();
		if (offering) begin
			req_valid <= 1'b0;
			offering = 1'b0;
		end
		// let the monitor note a beat accepted at this same edge
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.configure(idx, d);
	endtask

	task automatic set_config(input logic [1:0] kind, input logic [7:0] rom_n,
			input logic [2:0] ram_n, input logic bankable);
		write_reg(CFG_MAPPER_KIND, {6'd0, kind});
		write_reg(CFG_ROM_BANK_COUNT, rom_n);
		write_reg(CFG_RAM_BANK_COUNT, {5'd0, ram_n});
		write_reg(CFG_RAM_BANKING, {7'd0, bankable});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [1:0] kind, input logic [7:0] rom_n,
			input logic [2:0] ram_n, input logic bankable, input int count,
			input int odds, input bit squeeze);
		req_t r;
		settle();
		set_config(kind, rom_n, ram_n, bankable);
		idle_odds = squeeze ? 0 : odds;
		stall_odds = odds;
		if (squeeze)
			hold_pending = 1'b1;
		repeat (count) begin
			r = random_access();
			send_access(r);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAPPER_KIND;
		cfg_data = 8'd0;
		idle_odds = 3;
		stall_odds = 3;
		hold_pending = 1'b0;
		offering = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, no mapper: bank writes are dropped
		send_access(access(ACC_READ, 16'h0000, 8'h00));
		send_access(access(ACC_READ, 16'h7FFF, 8'h00));
		send_access(access(ACC_WRITE, 16'h2000, 8'h05));
		send_access(access(ACC_READ, 16'h8000, 8'h00));
		send_access(access(ACC_WRITE, 16'hFFFF, 8'hFF));
		send_access(access(ACC_READ, 16'hA000, 8'h00));

		// MBC1: enable, top bank, skipped bank, RAM banking mode, disable
		settle();
		set_config(MAPPER_MBC1, 8'd128, 3'd4, 1'b1);
		send_access(access(ACC_WRITE, 16'h0000, 8'h0A));
		send_access(access(ACC_READ, 16'hBFFF, 8'h00));
		send_access(access(ACC_WRITE, 16'h3FFF, 8'h1F));
		send_access(access(ACC_WRITE, 16'h4000, 8'h03));
		send_access(access(ACC_READ, 16'h4000, 8'h00));
		send_access(access(ACC_WRITE, 16'h2000, 8'h00));
		send_access(access(ACC_READ, 16'h5555, 8'h00));
		send_access(access(ACC_WRITE, 16'h6000, 8'h01));
		send_access(access(ACC_WRITE, 16'hA000, 8'hAA));
		send_access(access(ACC_WRITE, 16'h7FFF, 8'h00));
		send_access(access(ACC_WRITE, 16'h1FFF, 8'hF0));
		send_access(access(ACC_READ, 16'hA001, 8'h00));

		// MBC2: wrong bit 8 ignored on both registers
		settle();
		set_config(MAPPER_MBC2, 8'd16, 3'd1, 1'b0);
		send_access(access(ACC_WRITE, 16'h0100, 8'h0A));
		send_access(access(ACC_WRITE, 16'h0000, 8'h3A));
		send_access(access(ACC_WRITE, 16'h2100, 8'hFF));
		send_access(access(ACC_WRITE, 16'h3E00, 8'h07));
		send_access(access(ACC_READ, 16'h7FFF, 8'h00));
		send_access(access(ACC_READ, 16'hA000, 8'h00));

		// reserved mapper code acts as none; ROM count 0 gives empty ROM area
		settle();
		set_config(MAPPER_RSVD, 8'd0, 3'd7, 1'b1);
		send_access(access(ACC_WRITE, 16'h2000, 8'h01));
		send_access(access(ACC_READ, 16'hBFFF, 8'h00));

		// random traffic across settings; third phase holds results off
		run_phase(MAPPER_MBC1, 8'd128, 3'd4, 1'b1, 80, 4, 1'b0);
		run_phase(MAPPER_MBC1, 8'd2, 3'd0, 1'b0, 60, 0, 1'b0);
		run_phase(MAPPER_MBC1, 8'd0, 3'd7, 1'b1, 70, 3, 1'b1);
		run_phase(MAPPER_MBC2, 8'd16, 3'd1, 1'b0, 70, 2, 1'b0);
		run_phase(MAPPER_MBC1, 8'd255, 3'd2, 1'b1, 70, 5, 1'b0);
		run_phase(MAPPER_RSVD, 8'd64, 3'd3, 1'b1, 40, 3, 1'b0);
		run_phase(MAPPER_MBC2, 8'd128, 3'd4, 1'b1, 60, 4, 1'b0);
		run_phase(MAPPER_NONE, 8'd32, 3'd2, 1'b0, 40, 2, 1'b0);
		repeat (2)
			run_phase(2'($urandom_range(0, 3)), 8'(1 << $urandom_range(1, 7)),
				3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 50,
				$urandom_range(2, 6), 1'b0);
		// closing stretch at full rate on both sides
		run_phase(MAPPER_MBC1, 8'd64, 3'd4, 1'b1, 70, 0, 1'b0);

		settle();
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cbc_pkg.sv
sv/cartridge_bank_controller_core.sv
tb/testbench.sv
